// ----- design/adc_temp_two_digit_display_defines.svh -----
// Assertion macros for the two-digit temperature display.
// No dependencies; included by the RTL files that carry assertions.
`ifndef ADC_TEMP_TWO_DIGIT_DISPLAY_DEFINES_SVH
`define ADC_TEMP_TWO_DIGIT_DISPLAY_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ATTDD_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ATTDD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/attdd_pkg.sv -----
// Package for the two-digit temperature display: field widths, scaling
// constants and the seven-segment table. No dependencies.
`default_nettype none

package attdd_pkg;

    localparam int SampleWidth  = 10;
    localparam int TempWidth    = 7;
    localparam int DigitWidth   = 4;
    localparam int SegWidth     = 7;
    localparam int ScaledWidth  = 16;

    localparam int S_DATA_WIDTH = 24;
    localparam int M_DATA_WIDTH = 8;
    localparam int M_USER_WIDTH = 2;

    localparam int ScaleMul     = 50;
    localparam int RoundBias    = 511;
    localparam int FullScale    = 1023;
    localparam int TempOffset   = 15;
    localparam int TempMax      = 65;

    localparam int DigitBase    = 10;
    localparam int Div10Mul     = 205;
    localparam int Div10Shift   = 11;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef logic [SegWidth-1:0] seg_t;

    localparam seg_t SEG_TABLE [16] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
        7'h7F, 7'h6F, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

endpackage

`default_nettype wire

// ----- design/adc_temp_two_digit_display.sv -----
// Two-digit multiplexed seven-segment temperature display, top level.
// Depends on attdd_pkg and adc_temp_two_digit_display_defines.svh.
//
// Each input transfer is a sample pair (tuser 0) or a refresh tick (tuser 1).
// A sample pair is averaged, scaled to 15..65 and stored, and gives no
// output. A tick shows the ones digit, then the tens digit on the next
// tick, and so on, starting with ones after reset. One transfer is taken
// every cycle while the result side keeps up; a tick that waits behind an
// unread result holds the input register and stalls the input. A tick
// passes from the input register to the result register, with the digit
// decode in between; a sample pair is scaled between the input register
// and the stored temperature.
`default_nettype none
`include "adc_temp_two_digit_display_defines.svh"

module adc_temp_two_digit_display (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output      logic                                s_tready,
    // [9:0] sample_first, [19:10] sample_second, [23:20] zero
    input  wire logic [attdd_pkg::S_DATA_WIDTH-1:0]  s_tdata,
    // [0] cmd
    input  wire logic                                s_tuser,
    output      logic                                m_tvalid,
    input  wire logic                                m_tready,
    // [6:0] segment_bits, [7] zero
    output      logic [attdd_pkg::M_DATA_WIDTH-1:0]  m_tdata,
    // [0] tens_enable, [1] ones_enable
    output      logic [attdd_pkg::M_USER_WIDTH-1:0]  m_tuser
);

    logic                                 in_valid_reg;
    logic                                 in_cmd_reg;
    logic [attdd_pkg::SampleWidth-1:0]    in_first_reg;
    logic [attdd_pkg::SampleWidth-1:0]    in_second_reg;

    logic [attdd_pkg::TempWidth-1:0]      temp_reg;
    logic [attdd_pkg::TempWidth-1:0]      temp_next;
    logic                                 show_tens_reg;

    logic                                 out_valid_reg;
    logic [attdd_pkg::SegWidth-1:0]       out_seg_reg;
    logic                                 out_tens_reg;
    logic                                 out_ones_reg;

    logic                                 advance;
    logic                                 tick_go;

    logic [attdd_pkg::SampleWidth:0]      sum;
    logic [attdd_pkg::SampleWidth-1:0]    avg;
    logic [attdd_pkg::ScaledWidth-1:0]    scaled;
    logic [5:0]                           quot_low;
    logic [attdd_pkg::SampleWidth:0]      rem;
    logic [5:0]                           quot;

    logic [14:0]                          div10_prod;
    logic [attdd_pkg::DigitWidth-1:0]     tens;
    logic [attdd_pkg::TempWidth-1:0]      ones_wide;
    logic [attdd_pkg::DigitWidth-1:0]     ones;
    logic [attdd_pkg::DigitWidth-1:0]     digit;

    assign advance  = in_valid_reg
                   && ((in_cmd_reg == attdd_pkg::CMD_SAMPLE) || !out_valid_reg || m_tready);
    assign tick_go  = advance && (in_cmd_reg == attdd_pkg::CMD_TICK);
    assign s_tready = !in_valid_reg || advance;

    // scale: floor(x / 1023) from x / 1024 plus one correction step
    always_comb begin
        sum       = {1'b0, in_first_reg} + {1'b0, in_second_reg};
        avg       = sum[attdd_pkg::SampleWidth:1];
        scaled    = attdd_pkg::ScaledWidth'({6'd0, avg}
                        * attdd_pkg::ScaledWidth'(attdd_pkg::ScaleMul))
                  + attdd_pkg::ScaledWidth'(attdd_pkg::RoundBias);
        quot_low  = scaled[15:10];
        rem       = {1'b0, scaled[9:0]} + {5'd0, quot_low};
        if (rem >= 11'(attdd_pkg::FullScale)) begin
            quot = quot_low + 6'd1;
        end else begin
            quot = quot_low;
        end
        temp_next = 7'(quot) + 7'(attdd_pkg::TempOffset);
    end

    // digit split: v / 10 as (v * 205) >> 11
    always_comb begin
        div10_prod = 15'(temp_reg) * 15'(attdd_pkg::Div10Mul);
        tens       = div10_prod[14:attdd_pkg::Div10Shift];
        ones_wide  = temp_reg - 7'(7'(tens) * 7'(attdd_pkg::DigitBase));
        ones       = ones_wide[attdd_pkg::DigitWidth-1:0];
        digit      = show_tens_reg ? tens : ones;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_cmd_reg    <= s_tuser;
            in_first_reg  <= s_tdata[9:0];
            in_second_reg <= s_tdata[19:10];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_reg      <= '0;
            show_tens_reg <= 1'b0;
        end else begin
            if (advance && (in_cmd_reg == attdd_pkg::CMD_SAMPLE)) begin
                temp_reg <= temp_next;
            end
            if (tick_go) begin
                show_tens_reg <= !show_tens_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (tick_go) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (tick_go) begin
            out_seg_reg  <= attdd_pkg::SEG_TABLE[digit];
            out_tens_reg <= show_tens_reg;
            out_ones_reg <= !show_tens_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_seg_reg};
    assign m_tuser  = {out_ones_reg, out_tens_reg};

    `ATTDD_ASSERT_IMPL(a_one_enable, aclk, aresetn, m_tvalid, $onehot(m_tuser))
    `ATTDD_ASSERT_IMPL(a_temp_range, aclk, aresetn, 1'b1,
        (temp_reg == '0) || ((temp_reg >= 7'(attdd_pkg::TempOffset))
        && (temp_reg <= 7'(attdd_pkg::TempMax))))
    `ATTDD_ASSERT_NEXT(a_tick_toggles, aclk, aresetn, tick_go,
        show_tens_reg != $past(show_tens_reg))
    `ATTDD_ASSERT_NEXT(a_tick_held, aclk, aresetn,
        in_valid_reg && (in_cmd_reg == attdd_pkg::CMD_TICK) && m_tvalid && !m_tready,
        in_valid_reg && (in_cmd_reg == attdd_pkg::CMD_TICK))
    `ATTDD_ASSERT_NEXT(a_out_drains, aclk, aresetn, m_tvalid && m_tready && !tick_go,
        !m_tvalid)

endmodule

`default_nettype wire
